// ----- sv/tmvg_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tmvg_pkg
// Shared types and constants of the text-mode video generator.
// ============================================================================
package tmvg_pkg;

    // Field and storage widths
    localparam int ACTION_W = 2;
    localparam int ADDR_W   = 10;
    localparam int DATA_W   = 8;
    localparam int COL_W    = 6;
    localparam int LINE_W   = 9;
    localparam int SUB_W    = 3;
    localparam int MEM_DEPTH = 1 << ADDR_W;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_CODE_WR  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_GLYPH_WR = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_SCAN     = 2'd2;

    // Configuration port
    localparam int PADDR_W = 2;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-1:0] REG_REFRESH_60HZ = 2'd0;

    // Raster geometry
    localparam int LINE_BYTES       = 52;
    localparam int SCREEN_COLUMNS   = 32;
    localparam int SCREEN_TEXT_ROWS = 24;
    localparam int SCREEN_LINES     = 8 * SCREEN_TEXT_ROWS;
    localparam int TOP_50HZ         = 56;
    localparam int BOTTOM_50HZ      = 64;
    localparam int TOP_60HZ         = 32;
    localparam int BOTTOM_60HZ      = 40;
    localparam int LAST_50HZ        = TOP_50HZ + SCREEN_LINES + BOTTOM_50HZ - 1;
    localparam int LAST_60HZ        = TOP_60HZ + SCREEN_LINES + BOTTOM_60HZ - 1;

    localparam logic [6:0] GLYPH_INDEX_MASK = 7'h7F;

    // Input item
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [ADDR_W-1:0]   address;
        logic [DATA_W-1:0]   write_data;
    } req_item_t;

    // Result item
    typedef struct packed {
        logic [DATA_W-1:0] pixel_byte;
        logic              line_end;
        logic              frame_end;
    } rsp_item_t;

    // Beam position decode handed to the fetch pipeline
    typedef struct packed {
        logic              in_window;
        logic [ADDR_W-1:0] code_addr;
        logic [SUB_W-1:0]  sub_line;
        logic              line_end;
        logic              frame_end;
    } beam_info_t;

endpackage

// ----- sv/tmvg_beam.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tmvg_beam
// Beam column/line counters and screen-window decode for the current byte.
// ============================================================================
module tmvg_beam
    import tmvg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       scan,
    input  logic       refresh_60hz,
    output beam_info_t beam
);

    logic [COL_W-1:0]  column_reg, column_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic [LINE_W-1:0] top_line;
    logic [LINE_W-1:0] last_line;
    logic [LINE_W-1:0] rel_line;

    // Frame geometry for the selected refresh rate
    assign top_line  = refresh_60hz ? LINE_W'(TOP_60HZ)  : LINE_W'(TOP_50HZ);
    assign last_line = refresh_60hz ? LINE_W'(LAST_60HZ) : LINE_W'(LAST_50HZ);
    assign rel_line  = line_reg - top_line;

    // Decode of the byte under the beam
    always_comb
    begin
        beam.in_window = (line_reg >= top_line)
                      && (rel_line < LINE_W'(SCREEN_LINES))
                      && (column_reg < COL_W'(SCREEN_COLUMNS));
        // row * 32 + column
        beam.code_addr = {rel_line[7:3], column_reg[4:0]};
        beam.sub_line  = rel_line[SUB_W-1:0];
        beam.line_end  = (column_reg >= COL_W'(LINE_BYTES - 1));
        beam.frame_end = beam.line_end && (line_reg >= last_line);
    end

    // Advance one byte per scan tick
    always_comb
    begin
        column_next = column_reg;
        line_next   = line_reg;
        if (scan)
        begin
            if (beam.line_end)
            begin
                column_next = '0;
                line_next   = beam.frame_end ? '0 : line_reg + 1'b1;
            end
            else
            begin
                column_next = column_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= '0;
            line_reg   <= '0;
        end
        else
        begin
            column_reg <= column_next;
            line_reg   <= line_next;
        end
    end

endmodule

// ----- sv/tmvg_fetch.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tmvg_fetch
// Code and glyph memories with a two-stage read pipeline: code lookup, then
// glyph row lookup, then inversion and border blanking.
// ============================================================================
module tmvg_fetch
    import tmvg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              scan,
    input  logic              code_wr,
    input  logic              glyph_wr,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  beam_info_t        beam,
    output logic              result_valid,
    output rsp_item_t         result
);

    logic [DATA_W-1:0] code_mem  [MEM_DEPTH];
    logic [DATA_W-1:0] glyph_mem [MEM_DEPTH];

    // Stage 1: code read
    logic              s1_valid_reg;
    logic [DATA_W-1:0] s1_code_reg;
    logic              s1_window_reg;
    logic [SUB_W-1:0]  s1_sub_reg;
    logic              s1_lend_reg;
    logic              s1_fend_reg;

    // Stage 2: glyph read
    logic              s2_valid_reg;
    logic [DATA_W-1:0] s2_glyph_reg;
    logic              s2_invert_reg;
    logic              s2_window_reg;
    logic              s2_lend_reg;
    logic              s2_fend_reg;

    logic [ADDR_W-1:0] glyph_addr;

    // Code memory: write port and registered read port
    always_ff @(posedge clk)
    begin
        if (code_wr)
        begin
            code_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_code_reg <= code_mem[beam.code_addr];
        end
    end

    // Glyph memory: write port and registered read port (old data on collision)
    assign glyph_addr = {s1_code_reg[6:0] & GLYPH_INDEX_MASK, s1_sub_reg};

    always_ff @(posedge clk)
    begin
        if (glyph_wr)
        begin
            glyph_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_glyph_reg <= glyph_mem[glyph_addr];
        end
    end

    // Side-band payload through the stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_window_reg <= beam.in_window;
            s1_sub_reg    <= beam.sub_line;
            s1_lend_reg   <= beam.line_end;
            s1_fend_reg   <= beam.frame_end;
            s2_invert_reg <= s1_code_reg[DATA_W-1];
            s2_window_reg <= s1_window_reg;
            s2_lend_reg   <= s1_lend_reg;
            s2_fend_reg   <= s1_fend_reg;
        end
    end

    // Valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= scan;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Inversion and border blanking
    always_comb
    begin
        result.pixel_byte = s2_window_reg
                          ? (s2_glyph_reg ^ {DATA_W{s2_invert_reg}})
                          : '0;
        result.line_end   = s2_lend_reg;
        result.frame_end  = s2_fend_reg;
    end

    assign result_valid = s2_valid_reg;

endmodule

// ----- sv/text_mode_video_generator_unit.sv -----
`timescale 1ns / 1ps
// ============================================================================
// text_mode_video_generator_unit
// Character-mapped video generator, 32x24 cells on a 52-byte scan line.
// ============================================================================
// Usage:
//   req channel (req_valid/req_stall/req_data) carries one action per
//   transfer: a code memory write, a glyph memory write or a scan tick.
//   Writes produce no result. Each scan tick produces one rsp transfer with
//   the pixel octet at the beam position plus line_end/frame_end flags.
//   Throughput: one item per cycle while req_stall is low, writes and ticks
//   freely mixed. A scan tick's result passes the code read, the glyph read
//   and the output register before it is offered on rsp.
//   When rsp_stall holds a valid result, the whole pipeline freezes and
//   req_stall is raised in the same cycle; nothing is dropped.
//   Reset clears the beam to line 0 / column 0, selects the 50 Hz frame and
//   empties the pipeline. Memory contents are undefined until written.
//   APB register 0 (bit 0) selects the 60 Hz frame; write it only while idle.
// ============================================================================
module text_mode_video_generator_unit
    import tmvg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // request channel
    input  logic               req_valid,
    output logic               req_stall,
    input  req_item_t          req_data,
    // result channel
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output rsp_item_t          rsp_data,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic       refresh_60hz_reg;
    logic       rsp_valid_reg;
    rsp_item_t  rsp_data_reg;
    logic       en;
    logic       req_xfer;
    logic       scan;
    logic       code_wr;
    logic       glyph_wr;
    logic       result_valid;
    rsp_item_t  result;
    beam_info_t beam;

    // Pipeline moves whenever the output register is free or being drained
    assign en        = !rsp_valid_reg || !rsp_stall;
    assign req_stall = !en;
    assign req_xfer  = req_valid && en;

    // Action decode
    always_comb
    begin
        scan     = 1'b0;
        code_wr  = 1'b0;
        glyph_wr = 1'b0;
        unique case (req_data.action)
            ACT_CODE_WR:  code_wr  = req_xfer;
            ACT_GLYPH_WR: glyph_wr = req_xfer;
            ACT_SCAN:     scan     = req_xfer;
            default:      ;
        endcase
    end

    tmvg_beam u_beam (
        .clk          (clk),
        .rst_n        (rst_n),
        .scan         (scan),
        .refresh_60hz (refresh_60hz_reg),
        .beam         (beam)
    );

    tmvg_fetch u_fetch (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .scan         (scan),
        .code_wr      (code_wr),
        .glyph_wr     (glyph_wr),
        .wr_addr      (req_data.address),
        .wr_data      (req_data.write_data),
        .beam         (beam),
        .result_valid (result_valid),
        .result       (result)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            rsp_valid_reg <= result_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rsp_data_reg <= result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            refresh_60hz_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready && (paddr == REG_REFRESH_60HZ))
        begin
            refresh_60hz_reg <= pwdata[0];
        end
    end

    assign pready = 1'b1;

    always_comb
    begin
        prdata = '0;
        if (paddr == REG_REFRESH_60HZ)
        begin
            prdata[0] = refresh_60hz_reg;
        end
    end

endmodule

// ----- sv/tmvg_checker.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tmvg_checker
// Port-level checks of the text-mode video generator, bound to the top level.
// ============================================================================
module tmvg_checker
    import tmvg_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      req_stall,
    input logic      rsp_valid,
    input logic      rsp_stall,
    input rsp_item_t rsp_data
);

    // A stalled result stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> $stable(rsp_data))
        else $error("result changed while stalled");

    // The last byte of a frame is also the last byte of a line
    a_frame_line: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (!rsp_data.frame_end || rsp_data.line_end))
        else $error("frame_end without line_end");

    // No new request is taken while a finished result is held back
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |-> req_stall)
        else $error("request taken while output is stalled");

endmodule

bind text_mode_video_generator_unit tmvg_checker u_tmvg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
);
